FILE: hdl/fbu_pkg.sv
// ----------------------------------------------------------------------------
// fbu_pkg
// Shared types, constants and helpers of the frame-of-reference bit unpacker.
// ----------------------------------------------------------------------------
package fbu_pkg;

  // default parameter values
  localparam int unsigned MaxWidthDef   = 64;
  localparam int unsigned CountBitsDef  = 32;

  // fixed field widths
  localparam int unsigned WidthRegW = 7;   // value_width register
  localparam int unsigned OutW      = 64;  // result value
  localparam int unsigned ByteW     = 8;   // packed input byte
  localparam int unsigned PosW      = 4;   // bit position 0..8 inside a byte
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CountRegW = 32;  // value_count register

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_VALUE_WIDTH = 2'd0,
    REG_OUTPUT_SIZE = 2'd1,
    REG_BASE_VALUE  = 2'd2,
    REG_VALUE_COUNT = 2'd3
  } cfg_reg_e;

  // result wrap width
  typedef enum logic [1:0] {
    OSIZE_8  = 2'd0,
    OSIZE_16 = 2'd1,
    OSIZE_32 = 2'd2,
    OSIZE_64 = 2'd3
  } out_size_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic [WidthRegW-1:0] eff_width;  // clamped value width
    out_size_e            out_size;
    logic [OutW-1:0]      base;
  } fbu_cfg_t;

  // mask that wraps a result to the selected output size
  function automatic logic [OutW-1:0] out_mask(out_size_e size);
    logic [OutW-1:0] m;
    case (size)
      OSIZE_8:  m = 64'h0000_0000_0000_00FF;
      OSIZE_16: m = 64'h0000_0000_0000_FFFF;
      OSIZE_32: m = 64'h0000_0000_FFFF_FFFF;
      default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

FILE: hdl/fbu_unpack.sv
// ----------------------------------------------------------------------------
// fbu_unpack
// Byte holding register, single-pass value extraction and result register.
// ----------------------------------------------------------------------------
module fbu_unpack #(
  parameter int unsigned MAX_WIDTH = fbu_pkg::MaxWidthDef,
  parameter int unsigned CNT_W     = fbu_pkg::CountRegW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fbu_pkg::fbu_cfg_t         cfg_i,
  input  logic [CNT_W-1:0]          value_count_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [fbu_pkg::ByteW-1:0] packed_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [fbu_pkg::OutW-1:0]  value_o,
  output logic                      run_last_o,
  output logic                      stream_done_o
);
  import fbu_pkg::*;

  localparam int unsigned FillW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // held byte and stream state
  logic                  hold_valid_q, hold_valid_d;
  logic [ByteW-1:0]      byte_q, byte_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [MAX_WIDTH-1:0]  partial_q, partial_d;
  logic [FillW-1:0]      fill_q, fill_d;
  logic [CNT_W-1:0]      done_cnt_q, done_cnt_d;

  // result register
  logic                  out_valid_q, out_valid_d;
  logic [OutW-1:0]       value_q, value_d;
  logic                  run_last_q, run_last_d;
  logic                  stream_done_q, stream_done_d;

  // datapath signals
  logic [WidthRegW-1:0]  fill_ext, pos_ext, need, rem_now, rem_next;
  logic [WidthRegW-1:0]  pos_sum;
  logic [PosW-1:0]       pos_next;
  logic                  fits;
  logic [MAX_WIDTH-1:0]  bits_now, merged, wmask, raw;
  logic [OutW-1:0]       sum_full;
  logic [CNT_W:0]        cnt_inc;
  logic                  stop_now, stop_next, last;
  logic                  out_free, emit, consume, accept;

  // bits still needed for the current value and where they end in the byte
  always_comb begin
    fill_ext = WidthRegW'(fill_q);
    pos_ext  = WidthRegW'(pos_q);
    need     = (fill_ext >= cfg_i.eff_width) ? WidthRegW'(1) : (cfg_i.eff_width - fill_ext);
    pos_sum  = pos_ext + need;
    fits     = (pos_sum <= WidthRegW'(ByteW));
    pos_next = pos_sum[PosW-1:0];
    rem_now  = WidthRegW'(ByteW) - pos_ext;
    rem_next = WidthRegW'(ByteW) - WidthRegW'(pos_next);
  end

  // value assembly, base add and wrap
  always_comb begin
    bits_now = MAX_WIDTH'(byte_q >> pos_q);
    merged   = partial_q | (bits_now << fill_q);
    wmask    = (cfg_i.eff_width >= WidthRegW'(MAX_WIDTH)) ? '1
             : ((MAX_WIDTH'(1) << cfg_i.eff_width) - MAX_WIDTH'(1));
    raw      = merged & wmask;
    sum_full = (cfg_i.base + OutW'(raw)) & out_mask(cfg_i.out_size);
  end

  // stream end tracking
  always_comb begin
    cnt_inc   = {1'b0, done_cnt_q} + (CNT_W + 1)'(1);
    stop_now  = (done_cnt_q >= value_count_i);
    stop_next = (cnt_inc >= {1'b0, value_count_i});
    last      = stop_next || (rem_next < cfg_i.eff_width);
  end

  // handshake control
  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    emit       = hold_valid_q && !stop_now && fits && out_free;
    consume    = hold_valid_q && (stop_now || !fits || (emit && last));
    in_stall_o = hold_valid_q && !consume;
    accept     = in_valid_i && !in_stall_o;
  end

  // next state
  always_comb begin
    hold_valid_d  = hold_valid_q;
    byte_d        = byte_q;
    pos_d         = pos_q;
    partial_d     = partial_q;
    fill_d        = fill_q;
    done_cnt_d    = done_cnt_q;
    out_valid_d   = out_valid_q;
    value_d       = value_q;
    run_last_d    = run_last_q;
    stream_done_d = stream_done_q;

    if (emit) begin
      done_cnt_d    = cnt_inc[CNT_W-1:0];
      pos_d         = pos_next;
      value_d       = sum_full;
      run_last_d    = last;
      stream_done_d = stop_next;
      if (last && !stop_next) begin
        // rest of the byte starts the next value
        partial_d = MAX_WIDTH'(byte_q >> pos_next);
        fill_d    = FillW'(rem_next);
      end else begin
        partial_d = '0;
        fill_d    = '0;
      end
    end else if (hold_valid_q && !stop_now && !fits) begin
      // whole rest of the byte goes into the partial value
      partial_d = merged;
      fill_d    = FillW'(fill_ext + rem_now);
    end

    // result register
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end

    // byte holding register
    if (accept) begin
      hold_valid_d = 1'b1;
      byte_d       = packed_byte_i;
      pos_d        = '0;
    end else if (consume) begin
      hold_valid_d = 1'b0;
    end
  end

  // control and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      pos_q        <= '0;
      partial_q    <= '0;
      fill_q       <= '0;
      done_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      pos_q        <= pos_d;
      partial_q    <= partial_d;
      fill_q       <= fill_d;
      done_cnt_q   <= done_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    byte_q        <= byte_d;
    value_q       <= value_d;
    run_last_q    <= run_last_d;
    stream_done_q <= stream_done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign run_last_o    = run_last_q;
  assign stream_done_o = stream_done_q;

  // the final value of a stream always closes its byte's run
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_done_o |-> run_last_o)
    else $error("stream_done without run_last");

  // bit position never runs past the byte
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> (pos_q <= PosW'(ByteW)))
    else $error("bit position beyond byte");

  // an accepted byte is held from its first bit
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> hold_valid_q && (pos_q == '0))
    else $error("accepted byte not loaded");

  // nothing follows the final value of a stream
  a_quiet_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && stream_done_o |=> !out_valid_o)
    else $error("result after end of stream");

endmodule

FILE: hdl/for_bit_unpacker_top.sv
// ----------------------------------------------------------------------------
// for_bit_unpacker_top
// Frame-of-reference bit unpacker: packed LSB-first bytes in, base plus value
// results out, wrapped to the selected output size.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ---------------------------------
//  input     in         in_valid_i/in_stall_o  packed_byte_i
//  output    out        out_valid_o/out_stall_i value_o, run_last_o, stream_done_o
//  config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  The extraction logic yields the results of a byte one after another, and the
//  byte stays held until it has yielded its last one: eight results at width 1, one at width 8.
//  A taken byte goes into the byte holding register, and its results then into the output register.
//  The next byte is taken in the cycle the current one yields its last result.
//  Reset clears the stream state and returns the registers to their defaults.
//  A stalled output holds the byte register once the next result is ready.
//
module for_bit_unpacker_top #(
  parameter int unsigned MAX_WIDTH  = fbu_pkg::MaxWidthDef,
  parameter int unsigned COUNT_BITS = fbu_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fbu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fbu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fbu_pkg::ByteW-1:0]    packed_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fbu_pkg::OutW-1:0]     value_o,
  output logic                         run_last_o,
  output logic                         stream_done_o
);
  import fbu_pkg::*;

  localparam int unsigned CntW = (COUNT_BITS < CountRegW) ? COUNT_BITS : CountRegW;

  logic [WidthRegW-1:0] value_width_q;
  out_size_e            output_size_q;
  logic [OutW-1:0]      base_value_q;
  logic [CntW-1:0]      value_count_q;
  logic [WidthRegW-1:0] eff_width;
  fbu_cfg_t             cfg;

  // registers accept a write in every cycle
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_width_q <= WidthRegW'(8);
      output_size_q <= OSIZE_64;
      base_value_q  <= '0;
      value_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_VALUE_WIDTH: value_width_q <= cfg_data_i[WidthRegW-1:0];
        REG_OUTPUT_SIZE: output_size_q <= out_size_e'(cfg_data_i[1:0]);
        REG_BASE_VALUE:  base_value_q  <= cfg_data_i;
        REG_VALUE_COUNT: value_count_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // width zero counts as one, oversize widths clamp to the maximum
  always_comb begin
    if (value_width_q == '0) begin
      eff_width = WidthRegW'(1);
    end else if (value_width_q > WidthRegW'(MAX_WIDTH)) begin
      eff_width = WidthRegW'(MAX_WIDTH);
    end else begin
      eff_width = value_width_q;
    end
  end

  assign cfg.eff_width = eff_width;
  assign cfg.out_size  = output_size_q;
  assign cfg.base      = base_value_q;

  // datapath
  fbu_unpack #(
    .MAX_WIDTH (MAX_WIDTH),
    .CNT_W     (CntW)
  ) u_unpack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .value_count_i (value_count_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .packed_byte_i (packed_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o)
  );

endmodule
